/* src/svt_pkg.sv */
// ----------------------------------------------------------------------------
// svt_pkg
// Shared widths, constants and helpers for the shower valve timer controller.
// ----------------------------------------------------------------------------
package svt_pkg;

  localparam int PULSE_W    = 8;
  localparam int ELAPSED_W  = 16;
  localparam int WATCH_W    = 32;
  localparam int MINUTES_W  = 8;
  // 255 minutes * 60000 ms fits in 24 bits
  localparam int LIMIT_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int RUN_W      = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHOWER_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHUTOFF_MIN = 2'd1;

  // Bit positions in the run flags
  localparam int RUN_FLOW   = 0;
  localparam int RUN_PAUSE  = 1;
  localparam int RUN_CLOSED = 2;

  localparam logic [LIMIT_W-1:0] MS_PER_MIN     = LIMIT_W'(60000);
  localparam logic [WATCH_W-1:0] SHORT_FLOW_MS  = WATCH_W'(60000);
  localparam logic [WATCH_W-1:0] SHORT_PAUSE_MS = WATCH_W'(120000);

  localparam logic [MINUTES_W-1:0] SHOWER_MIN_RST  = MINUTES_W'(10);
  localparam logic [MINUTES_W-1:0] SHUTOFF_MIN_RST = MINUTES_W'(5);

  typedef logic [RUN_W-1:0]   run_flags_t;
  typedef logic [WATCH_W-1:0] watch_t;
  typedef logic [LIMIT_W-1:0] limit_t;

  // Minutes to milliseconds
  function automatic limit_t minutes_to_ms(input logic [MINUTES_W-1:0] minutes);
    return LIMIT_W'(minutes) * MS_PER_MIN;
  endfunction

  // Saturating stopwatch advance
  function automatic watch_t sat_add(input watch_t a, input logic [ELAPSED_W-1:0] b);
    logic [WATCH_W:0] sum;
    sum = {1'b0, a} + (WATCH_W + 1)'(b);
    return sum[WATCH_W] ? '1 : sum[WATCH_W-1:0];
  endfunction

endpackage

/* src/svt_if.sv */
// ----------------------------------------------------------------------------
// svt_in_if / svt_out_if
// Valid/ready channels for monitoring ticks and controller results.
// ----------------------------------------------------------------------------
interface svt_in_if;
  import svt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [PULSE_W-1:0]   pulse_count;
  logic [ELAPSED_W-1:0] elapsed_ms;

  modport source (output valid, output pulse_count, output elapsed_ms, input ready);
  modport sink   (input valid, input pulse_count, input elapsed_ms, output ready);
endinterface

interface svt_out_if;
  import svt_pkg::*;

  logic               valid;
  logic               ready;
  logic               valve_closed;
  logic               flowing;
  logic               paused;
  logic               closed_waiting;
  logic [WATCH_W-1:0] flow_ms;

  modport source (output valid, output valve_closed, output flowing, output paused,
                  output closed_waiting, output flow_ms, input ready);
  modport sink   (input valid, input valve_closed, input flowing, input paused,
                  input closed_waiting, input flow_ms, output ready);
endinterface

/* src/shower_valve_timer_controller_unit.sv */
// ----------------------------------------------------------------------------
// shower_valve_timer_controller_unit
// Shower time limiter: flow, pause and closed-valve stopwatches per tick.
// ----------------------------------------------------------------------------
// Each request on in_if is one monitoring tick (flow pulses, elapsed ms). The
// tick is captured in an input register; once the output register is free
// or being emptied, the three stopwatches advance, the start/pause/resume and
// limit rules are applied in one pass of logic, the state updates and the
// result lands in the output register, from which it is offered on out_if.
// One tick per cycle is sustained while out_if is ready; the state update
// for each tick completes before the next tick is processed.
// When out_if stalls, the output register holds its result and the input
// register holds one more tick; in_if.ready drops only when both are full.
// cfg_we writes shower or shutoff minutes (index 0 or 1, others ignored);
// a write also clears and stops all watches and keeps the valve state.
// Reset (rst_n low, synchronous) restores 10 and 5 minutes, stops and clears
// all watches, opens the valve and empties both registers.
// ----------------------------------------------------------------------------
module shower_valve_timer_controller_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [svt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [svt_pkg::CFG_DATA_W-1:0] cfg_data,
  svt_in_if.sink                         in_if,
  svt_out_if.source                      out_if
);
  import svt_pkg::*;

  // Limits and state
  limit_t     shower_lim_r;
  limit_t     shutoff_lim_r;
  watch_t     flow_watch_r;
  watch_t     pause_watch_r;
  watch_t     closed_watch_r;
  run_flags_t run_r;
  logic       valve_r;

  // Input register
  logic                 in_valid_r;
  logic [PULSE_W-1:0]   pulse_r;
  logic [ELAPSED_W-1:0] elapsed_r;

  // Output register
  logic   out_valid_r;
  logic   out_valve_r;
  logic   out_flowing_r;
  logic   out_paused_r;
  logic   out_closed_r;
  watch_t out_flow_ms_r;

  logic advance;
  logic in_fire;

  watch_t     flow_watch_nxt;
  watch_t     pause_watch_nxt;
  watch_t     closed_watch_nxt;
  run_flags_t run_nxt;
  logic       valve_nxt;

  assign advance     = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || advance;
  assign in_fire     = in_if.valid && in_if.ready;

  always_comb begin
    logic flow;
    flow = (pulse_r != '0);

    flow_watch_nxt   = run_r[RUN_FLOW]   ? sat_add(flow_watch_r, elapsed_r)   : flow_watch_r;
    pause_watch_nxt  = run_r[RUN_PAUSE]  ? sat_add(pause_watch_r, elapsed_r)  : pause_watch_r;
    closed_watch_nxt = run_r[RUN_CLOSED] ? sat_add(closed_watch_r, elapsed_r) : closed_watch_r;
    run_nxt          = run_r;
    valve_nxt        = valve_r;

    // Start, pause, resume
    if (flow && run_nxt == '0) begin
      flow_watch_nxt    = '0;
      run_nxt[RUN_FLOW] = 1'b1;
    end else if (!flow && run_nxt[RUN_FLOW]) begin
      run_nxt[RUN_FLOW]  = 1'b0;
      run_nxt[RUN_PAUSE] = 1'b1;
    end else if (flow && run_nxt[RUN_PAUSE] && flow_watch_nxt != '0) begin
      run_nxt[RUN_FLOW]  = 1'b1;
      run_nxt[RUN_PAUSE] = 1'b0;
    end

    // Limits
    if (run_nxt[RUN_FLOW]) begin
      if (flow_watch_nxt >= WATCH_W'(shower_lim_r) && !valve_r) begin
        flow_watch_nxt   = '0;
        pause_watch_nxt  = '0;
        closed_watch_nxt = '0;
        run_nxt          = '0;
        run_nxt[RUN_CLOSED] = 1'b1;
        valve_nxt        = 1'b1;
      end
    end else if (run_nxt[RUN_PAUSE]) begin
      if ((pause_watch_nxt >= WATCH_W'(shutoff_lim_r) && !valve_r) ||
          (flow_watch_nxt <= SHORT_FLOW_MS && pause_watch_nxt >= SHORT_PAUSE_MS && !flow)) begin
        flow_watch_nxt   = '0;
        pause_watch_nxt  = '0;
        closed_watch_nxt = '0;
        run_nxt          = '0;
      end
    end else if (run_nxt[RUN_CLOSED]) begin
      if (closed_watch_nxt >= WATCH_W'(shutoff_lim_r) && valve_r) begin
        flow_watch_nxt   = '0;
        pause_watch_nxt  = '0;
        closed_watch_nxt = '0;
        run_nxt          = '0;
        valve_nxt        = 1'b0;
      end
    end
  end

  // Control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shower_lim_r   <= minutes_to_ms(SHOWER_MIN_RST);
      shutoff_lim_r  <= minutes_to_ms(SHUTOFF_MIN_RST);
      flow_watch_r   <= '0;
      pause_watch_r  <= '0;
      closed_watch_r <= '0;
      run_r          <= '0;
      valve_r        <= 1'b0;
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == CFG_SHOWER_MIN || cfg_index == CFG_SHUTOFF_MIN)) begin
        unique case (cfg_index)
          CFG_SHOWER_MIN:  shower_lim_r  <= minutes_to_ms(cfg_data);
          CFG_SHUTOFF_MIN: shutoff_lim_r <= minutes_to_ms(cfg_data);
          default: ;
        endcase
        flow_watch_r   <= '0;
        pause_watch_r  <= '0;
        closed_watch_r <= '0;
        run_r          <= '0;
      end else if (advance) begin
        flow_watch_r   <= flow_watch_nxt;
        pause_watch_r  <= pause_watch_nxt;
        closed_watch_r <= closed_watch_nxt;
        run_r          <= run_nxt;
        valve_r        <= valve_nxt;
      end

      if (in_fire) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end

      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pulse_r   <= in_if.pulse_count;
      elapsed_r <= in_if.elapsed_ms;
    end
    if (advance) begin
      out_valve_r   <= valve_nxt;
      out_flowing_r <= run_nxt[RUN_FLOW];
      out_paused_r  <= run_nxt[RUN_PAUSE];
      out_closed_r  <= run_nxt[RUN_CLOSED];
      out_flow_ms_r <= flow_watch_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.valve_closed   = out_valve_r;
  assign out_if.flowing        = out_flowing_r;
  assign out_if.paused         = out_paused_r;
  assign out_if.closed_waiting = out_closed_r;
  assign out_if.flow_ms        = out_flow_ms_r;

  // Closed-valve watch runs only while the valve is closed
  a_closed_needs_valve: assert property (@(posedge clk) disable iff (!rst_n)
    run_r[RUN_CLOSED] |-> valve_r)
    else $error("closed watch running with valve open");

  // Closed-valve watch runs alone
  a_closed_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_closed_r |-> !out_flowing_r && !out_paused_r)
    else $error("closed watch running together with flow or pause");

  // An empty output register never blocks a new tick
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_if.ready)
    else $error("input stalled with empty output register");

  // A tick that moves on always produces a result
  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed tick produced no result");

endmodule
